### rtl/acrt_pkg.sv
// Package for the box collision table: entry layout, operation and result
// codes, and the coordinate saturation helper.
// No dependencies; used by the top level, the checkers and the testbench.
package acrt_pkg;

  localparam int unsigned MAX_BOXES_DEF = 32;
  // At most this many hit reports per query, followed by the final.
  localparam int unsigned MAX_HITS      = 32;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_HIT   = 2'd1;
  localparam logic [1:0] KIND_FINAL = 2'd2;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [11:0]        w;
    logic [11:0]        h;
    logic               phased;
  } entry_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### rtl/acrt_in_if.sv
// Input channel of the box collision table: valid/ready plus one item.
// Depends on nothing; carries the fields named as on the block's inputs.
interface acrt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [4:0]         index;
  logic               self_present;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] cur_x;
  logic signed [15:0] cur_y;
  logic [11:0]        box_width;
  logic [11:0]        box_height;
  logic               phased;

  modport source (
    output valid, op, index, self_present, pos_x, pos_y, cur_x, cur_y,
           box_width, box_height, phased,
    input  ready
  );
  modport sink (
    input  valid, op, index, self_present, pos_x, pos_y, cur_x, cur_y,
           box_width, box_height, phased,
    output ready
  );
  modport monitor (
    input valid, ready, op, index, self_present, pos_x, pos_y, cur_x, cur_y,
          box_width, box_height, phased
  );
endinterface

### rtl/acrt_out_if.sv
// Output channel of the box collision table: valid/ready plus one result item.
// Depends on nothing.
interface acrt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic               ok;
  logic [4:0]         hit_index;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic               last;

  modport source (
    output valid, kind, ok, hit_index, out_x, out_y, last,
    input  ready
  );
  modport sink (
    input  valid, kind, ok, hit_index, out_x, out_y, last,
    output ready
  );
  modport monitor (
    input valid, ready, kind, ok, hit_index, out_x, out_y, last
  );
endinterface

### rtl/aabb_collision_resolve_table_unit.sv
// Box collision table with push-out resolution. Add and update items are
// acknowledged in the cycle after acceptance. A query reads the table memory
// in order, one entry a cycle unless a hit report waits on the output; each
// push-out feeds the next overlap test. One item is worked at a time.
// Reset clears the entry count and the handshake state; the table contents
// are undefined until written and need no clearing pass.
module aabb_collision_resolve_table_unit #(
  parameter int unsigned MaxBoxes = acrt_pkg::MAX_BOXES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  acrt_in_if.sink    in_i,
  acrt_out_if.source out_o
);
  import acrt_pkg::*;

  localparam int unsigned CntW  = $clog2(MaxBoxes + 1);
  localparam int unsigned AddrW = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  entry_t mem [MaxBoxes];
  entry_t rd_q;

  logic              state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   idx_nxt;
  logic [5:0]        hits_q, hits_d;
  logic              clear_q, clear_d;

  logic signed [15:0] px_q, px_d, py_q, py_d;
  logic signed [15:0] cx_q, cy_q;
  logic [11:0]        w_q, h_q;
  logic               self_q;
  logic [4:0]         sidx_q;

  logic               out_vld_q, out_vld_d;
  logic [1:0]         kind_q, kind_d;
  logic               ok_q, ok_d;
  logic [4:0]         hidx_q, hidx_d;
  logic signed [15:0] ox_q, ox_d, oy_q, oy_d;
  logic               last_q, last_d;

  logic             out_free, load;
  logic             accept, wr_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  entry_t           wr_data;

  logic signed [17:0] tx, ty, tw, th, pxe, pye, cwe, che, dx, dy;
  logic               done, hit, skip, emit_hit, advance;
  logic signed [15:0] npx, npy;

  assign out_free = !out_vld_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign accept = in_i.valid && in_i.ready;
  assign idx_nxt = idx_q + 1'b1;

  // Overlap test and side rule for the entry now on the read port.
  always_comb begin
    tx  = 18'(rd_q.x);
    ty  = 18'(rd_q.y);
    tw  = $signed({6'b0, rd_q.w});
    th  = $signed({6'b0, rd_q.h});
    pxe = 18'(px_q);
    pye = 18'(py_q);
    cwe = $signed({6'b0, w_q});
    che = $signed({6'b0, h_q});
    dx  = 18'(cx_q) + cwe - tx;
    dy  = 18'(cy_q) + che - ty;
    skip = rd_q.phased || (self_q && (int'(idx_q) == int'(sidx_q)));
    hit  = !skip && (pxe < tx + tw) && (pxe + cwe > tx) &&
           (pye < ty + th) && (pye + che > ty);
    npx = px_q;
    npy = py_q;
    if (dx <= 18'sd0 && dx < dy) begin
      npx = sat16(tx - cwe);
    end else if (dy <= 18'sd0 && dy < dx) begin
      npy = sat16(ty - che);
    end else if (dx > 18'sd0 && dx > dy) begin
      npx = sat16(tx + tw);
    end else if (dy > 18'sd0 && dy > dx) begin
      npy = sat16(ty + th);
    end
  end

  assign done     = (idx_q == cnt_q);
  assign emit_hit = hit && (hits_q < 6'(MAX_HITS));
  assign advance  = (state_q == S_WALK) && !done && (!emit_hit || out_free);

  always_comb begin
    if (state_q == S_WALK && advance) begin
      rd_addr = (int'(idx_nxt) >= MaxBoxes) ? '0 : idx_nxt[AddrW-1:0];
    end else if (state_q == S_WALK) begin
      rd_addr = idx_q[AddrW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    hits_d  = hits_q;
    clear_d = clear_q;
    px_d    = px_q;
    py_d    = py_q;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '{x: in_i.pos_x, y: in_i.pos_y, w: in_i.box_width,
                h: in_i.box_height, phased: in_i.phased};
    load    = 1'b0;
    kind_d  = kind_q;
    ok_d    = ok_q;
    hidx_d  = hidx_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    last_d  = last_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.op == OP_QUERY) begin
            state_d = S_WALK;
            idx_d   = '0;
            hits_d  = '0;
            clear_d = 1'b1;
            px_d    = in_i.pos_x;
            py_d    = in_i.pos_y;
          end else begin
            load   = 1'b1;
            kind_d = KIND_ACK;
            ok_d   = 1'b0;
            hidx_d = '0;
            ox_d   = '0;
            oy_d   = '0;
            last_d = 1'b1;
            if (in_i.op == OP_ADD && int'(cnt_q) < MaxBoxes) begin
              wr_en   = 1'b1;
              wr_addr = cnt_q[AddrW-1:0];
              cnt_d   = cnt_q + 1'b1;
              ok_d    = 1'b1;
            end else if (in_i.op == OP_UPDATE && int'(in_i.index) < int'(cnt_q)) begin
              wr_en   = 1'b1;
              wr_addr = AddrW'(in_i.index);
              ok_d    = 1'b1;
            end
          end
        end
      end
      S_WALK: begin
        if (done) begin
          if (out_free) begin
            load    = 1'b1;
            kind_d  = KIND_FINAL;
            ok_d    = clear_q;
            hidx_d  = '0;
            ox_d    = px_q;
            oy_d    = py_q;
            last_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else if (advance) begin
          idx_d = idx_nxt;
          if (hit) begin
            px_d    = npx;
            py_d    = npy;
            clear_d = 1'b0;
          end
          if (emit_hit) begin
            load   = 1'b1;
            kind_d = KIND_HIT;
            ok_d   = 1'b0;
            hidx_d = 5'(idx_q);
            ox_d   = npx;
            oy_d   = npy;
            last_d = 1'b0;
            hits_d = hits_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      hits_q    <= '0;
      clear_q   <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      hits_q    <= hits_d;
      clear_q   <= clear_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    kind_q <= kind_d;
    ok_q   <= ok_d;
    hidx_q <= hidx_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    last_q <= last_d;
    if (accept && in_i.op == OP_QUERY) begin
      cx_q   <= in_i.cur_x;
      cy_q   <= in_i.cur_y;
      w_q    <= in_i.box_width;
      h_q    <= in_i.box_height;
      self_q <= in_i.self_present;
      sidx_q <= in_i.index;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.kind      = kind_q;
  assign out_o.ok        = ok_q;
  assign out_o.hit_index = hidx_q;
  assign out_o.out_x     = ox_q;
  assign out_o.out_y     = oy_q;
  assign out_o.last      = last_q;

endmodule

### rtl/acrt_checker.sv
// Port-level checks for the box collision table, bound to the top level.
// Depends on acrt_pkg and the two channel interfaces.
module acrt_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  acrt_in_if.sink    in_i,
  acrt_out_if.source out_o
);
  import acrt_pkg::*;

  // A result that waits is never replaced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.kind) &&
      $stable(out_o.out_x) && $stable(out_o.out_y))
    else $error("stalled result changed");

  // The block takes an item only when its output register can take a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid || out_o.ready)
    else $error("item accepted while output is blocked");

  // Hit reports never close an item and never claim a clear path.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.kind == KIND_HIT |-> !out_o.ok && !out_o.last)
    else $error("malformed hit report");

  // Acknowledges and finals close the item; acknowledges carry no position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.kind == KIND_ACK |->
      out_o.last && out_o.out_x == 16'sd0 && out_o.out_y == 16'sd0 &&
      out_o.hit_index == 5'd0)
    else $error("malformed acknowledge");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.kind == KIND_FINAL |-> out_o.last && out_o.hit_index == 5'd0)
    else $error("malformed query final");

endmodule

bind aabb_collision_resolve_table_unit acrt_port_checker u_acrt_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .in_i  (in_i),
  .out_o (out_o)
);

### tb/acrt_checker.sv
`timescale 1ns / 1ps
// Checker for the box collision table: keeps its own copy of the box table,
// predicts every result item from each accepted input item and compares them.
// Depends on acrt_pkg and the acrt_in_if / acrt_out_if channel interfaces.
module acrt_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  acrt_in_if.monitor  in_mon_i,
  acrt_out_if.monitor out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned results_due_o
);
  import acrt_pkg::*;

  localparam int unsigned MAX_BOXES = MAX_BOXES_DEF;

  typedef struct packed {
    logic [1:0]         kind;
    logic               ok;
    logic [4:0]         hit_index;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               last;
  } result_t;

  entry_t      boxes [MAX_BOXES];
  int unsigned box_count = 0;
  int unsigned failures  = 0;
  result_t     due_results [$];

  assign fail_count_o = failures;

  function automatic logic signed [15:0] clamp_coord(input int v);
    int c;
    c = v;
    if (c > 32767) begin
      c = 32767;
    end else if (c < -32768) begin
      c = -32768;
    end
    return c[15:0];
  endfunction

  function automatic entry_t latched_entry();
    entry_t e;
    e.x      = in_mon_i.pos_x;
    e.y      = in_mon_i.pos_y;
    e.w      = in_mon_i.box_width;
    e.h      = in_mon_i.box_height;
    e.phased = in_mon_i.phased;
    return e;
  endfunction

  // Walk the table in order; each push-out feeds the next overlap test.
  task automatic push_out_query();
    int          px, py, cx, cy, w, h, tx, ty, tw, th, dx, dy;
    int unsigned hits;
    logic        clear;
    result_t     r;
    px    = int'(in_mon_i.pos_x);
    py    = int'(in_mon_i.pos_y);
    cx    = int'(in_mon_i.cur_x);
    cy    = int'(in_mon_i.cur_y);
    w     = int'(in_mon_i.box_width);
    h     = int'(in_mon_i.box_height);
    hits  = 0;
    clear = 1'b1;
    for (int i = 0; i < int'(box_count); i++) begin
      if (boxes[i].phased) continue;
      if (in_mon_i.self_present && i == int'(in_mon_i.index)) continue;
      tx = int'(boxes[i].x);
      ty = int'(boxes[i].y);
      tw = int'(boxes[i].w);
      th = int'(boxes[i].h);
      if (px < tx + tw && px + w > tx && py < ty + th && py + h > ty) begin
        dx = cx + w - tx;
        dy = cy + h - ty;
        // The side is picked from the current position; equal depths move nothing.
        if (dx <= 0 && dx < dy) begin
          px = int'(clamp_coord(tx - w));
        end else if (dy <= 0 && dy < dx) begin
          py = int'(clamp_coord(ty - h));
        end else if (dx > 0 && dx > dy) begin
          px = int'(clamp_coord(tx + tw));
        end else if (dy > 0 && dy > dx) begin
          py = int'(clamp_coord(ty + th));
        end
        clear = 1'b0;
        if (hits < MAX_HITS) begin
          r           = '0;
          r.kind      = KIND_HIT;
          r.hit_index = 5'(i);
          r.out_x     = px[15:0];
          r.out_y     = py[15:0];
          due_results.push_back(r);
          hits++;
        end
      end
    end
    r       = '0;
    r.kind  = KIND_FINAL;
    r.ok    = clear;
    r.out_x = px[15:0];
    r.out_y = py[15:0];
    r.last  = 1'b1;
    due_results.push_back(r);
  endtask

  task automatic apply_table_op();
    result_t r;
    r      = '0;
    r.kind = KIND_ACK;
    r.last = 1'b1;
    if (in_mon_i.op == OP_QUERY) begin
      push_out_query();
    end else begin
      if (in_mon_i.op == OP_ADD && box_count < MAX_BOXES) begin
        boxes[box_count] = latched_entry();
        box_count++;
        r.ok = 1'b1;
      end else if (in_mon_i.op == OP_UPDATE && int'(in_mon_i.index) < int'(box_count)) begin
        boxes[in_mon_i.index] = latched_entry();
        r.ok = 1'b1;
      end
      due_results.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      failures++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      $display("%0t: result item with none expected, got kind %0d x %0d y %0d",
               $time, out_mon_i.kind, out_mon_i.out_x, out_mon_i.out_y);
      failures++;
    end else begin
      want = due_results.pop_front();
      check_field("kind", int'(want.kind), int'(out_mon_i.kind));
      check_field("ok", int'(want.ok), int'(out_mon_i.ok));
      check_field("hit_index", int'(want.hit_index), int'(out_mon_i.hit_index));
      check_field("out_x", int'(want.out_x), int'(out_mon_i.out_x));
      check_field("out_y", int'(want.out_y), int'(out_mon_i.out_y));
      check_field("last", int'(want.last), int'(out_mon_i.last));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        apply_table_op();
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        check_result();
      end
    end
    results_due_o <= due_results.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Top of the box collision table testbench: clock, reset, item stimulus and
// a result sink with random stalls; the checker beside the block does the compare.
// Depends on acrt_pkg, the channel interfaces, the block and acrt_checker.
module tb;
  import acrt_pkg::*;

  // The block answers any op outside the three known ones with a refusal.
  localparam logic [1:0]  OP_UNKNOWN   = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 2 * (MAX_BOXES_DEF + 1) + 10;

  typedef struct packed {
    logic [1:0]         op;
    logic [4:0]         index;
    logic               self_present;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic [11:0]        box_width;
    logic [11:0]        box_height;
    logic               phased;
  } cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        calm = 1'b0;
  int unsigned boxes_held = 0;
  int unsigned results_taken = 0;
  int unsigned fail_count;
  int unsigned results_due;

  acrt_in_if  cmd_ch ();
  acrt_out_if res_ch ();

  aabb_collision_resolve_table_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  acrt_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon_i      (cmd_ch),
    .out_mon_i     (res_ch),
    .fail_count_o  (fail_count),
    .results_due_o (results_due)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned draw_idle();
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic signed [15:0] near(input int unsigned span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - int'(span);
    return v[15:0];
  endfunction

  function automatic cmd_t box_cmd(input logic [1:0] op, input logic [4:0] index,
                                   input int x, input int y, input int w, input int h,
                                   input logic phased);
    cmd_t c;
    c            = '0;
    c.op         = op;
    c.index      = index;
    c.pos_x      = x[15:0];
    c.pos_y      = y[15:0];
    c.box_width  = w[11:0];
    c.box_height = h[11:0];
    c.phased     = phased;
    return c;
  endfunction

  function automatic cmd_t query_cmd(input logic [4:0] index, input logic self_present,
                                     input int px, input int py, input int cx, input int cy,
                                     input int w, input int h);
    cmd_t c;
    c              = box_cmd(OP_QUERY, index, px, py, w, h, 1'b0);
    c.self_present = self_present;
    c.cur_x        = cx[15:0];
    c.cur_y        = cy[15:0];
    return c;
  endfunction

  // Most items stay in a small cluster so that queries hit several boxes;
  // a few use the whole field range.
  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned pick;
    logic        wild;
    c    = '0;
    pick = $urandom_range(0, 99);
    wild = ($urandom_range(0, 6) == 0);
    if (pick < 20) begin
      c.op = OP_ADD;
    end else if (pick < 40) begin
      c.op = OP_UPDATE;
    end else if (pick < 95) begin
      c.op = OP_QUERY;
    end else begin
      c.op = OP_UNKNOWN;
    end
    if (boxes_held != 0 && $urandom_range(0, 3) != 0) begin
      c.index = 5'($urandom_range(0, boxes_held - 1));
    end else begin
      c.index = 5'($urandom_range(0, 31));
    end
    c.self_present = 1'($urandom_range(0, 1));
    c.phased       = ($urandom_range(0, 4) == 0);
    if (wild) begin
      c.pos_x      = 16'($urandom);
      c.pos_y      = 16'($urandom);
      c.cur_x      = 16'($urandom);
      c.cur_y      = 16'($urandom);
      c.box_width  = 12'($urandom);
      c.box_height = 12'($urandom);
    end else if (c.op == OP_QUERY) begin
      c.pos_x      = near(1600);
      c.pos_y      = near(1600);
      c.cur_x      = c.pos_x + near(300);
      c.cur_y      = c.pos_y + near(300);
      c.box_width  = 12'($urandom_range(0, 300));
      c.box_height = 12'($urandom_range(0, 300));
    end else begin
      c.pos_x      = near(1500);
      c.pos_y      = near(1500);
      c.box_width  = 12'($urandom_range(1, 400));
      c.box_height = 12'($urandom_range(1, 400));
    end
    return c;
  endfunction

  task automatic present(input cmd_t c);
    cmd_ch.op           <= c.op;
    cmd_ch.index        <= c.index;
    cmd_ch.self_present <= c.self_present;
    cmd_ch.pos_x        <= c.pos_x;
    cmd_ch.pos_y        <= c.pos_y;
    cmd_ch.cur_x        <= c.cur_x;
    cmd_ch.cur_y        <= c.cur_y;
    cmd_ch.box_width    <= c.box_width;
    cmd_ch.box_height   <= c.box_height;
    cmd_ch.phased       <= c.phased;
  endtask

  // Called at a rising edge; returns at the edge where the item is accepted.
  task automatic offer(input cmd_t c);
    int unsigned gap;
    gap = draw_idle();
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    present(c);
    do @(posedge clk_i); while (!cmd_ch.ready);
    if (c.op == OP_ADD && boxes_held < MAX_BOXES_DEF) begin
      boxes_held++;
    end
  endtask

  // Result side: a random stall after each item, and one long hold-off so
  // that the block backs up and stops taking input.
  initial begin : result_sink
    int unsigned wait_cycles;
    wait_cycles = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_ch.valid && res_ch.ready) begin
        results_taken++;
        wait_cycles = (results_taken == HOLD_AT) ? HOLD_CYCLES : draw_idle();
      end else if (wait_cycles != 0) begin
        wait_cycles--;
      end
      res_ch.ready <= (wait_cycles == 0);
    end
  end

  initial begin : stimulus
    rst_ni       <= 1'b0;
    cmd_ch.valid <= 1'b0;
    present('0);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, refused update and an unknown op with every bit set.
    offer(query_cmd(5'd0, 1'b0, 100, 100, 0, 0, 10, 10));
    offer(box_cmd(OP_UPDATE, 5'd0, 1, 1, 1, 1, 1'b0));
    offer(query_cmd(5'd31, 1'b1, -1, -1, -1, -1, 4095, 4095) | {OP_UNKNOWN, {95{1'b1}}});
    offer(box_cmd(OP_ADD, 5'd0, 0, 0, 100, 100, 1'b0));
    offer(box_cmd(OP_ADD, 5'd0, 0, 0, 100, 100, 1'b1));
    offer(box_cmd(OP_ADD, 5'd0, -32768, -32768, 4095, 4095, 1'b0));
    offer(box_cmd(OP_ADD, 5'd0, 32000, 0, 4095, 100, 1'b0));
    offer(box_cmd(OP_ADD, 5'd0, 500, 500, 0, 0, 1'b0));
    offer(box_cmd(OP_ADD, 5'd0, 200, 32000, 100, 4095, 1'b0));
    // Approach the first box from each of the four sides.
    offer(query_cmd(5'd0, 1'b0, -5, 40, -20, 40, 10, 10));
    offer(query_cmd(5'd0, 1'b0, 40, -5, 40, -20, 10, 10));
    offer(query_cmd(5'd0, 1'b0, 95, 40, 120, 40, 10, 10));
    offer(query_cmd(5'd0, 1'b0, 40, 95, 40, 150, 10, 10));
    // Equal depths on both axes: a hit that moves nothing.
    offer(query_cmd(5'd0, 1'b0, -5, -5, -10, -10, 10, 10));
    // The mover's own entry is skipped only with self_present set.
    offer(query_cmd(5'd0, 1'b1, -5, 40, -20, 40, 10, 10));
    offer(query_cmd(5'd0, 1'b0, 50, 50, -20, 40, 10, 10));
    // Push-outs past the top of the coordinate range saturate.
    offer(query_cmd(5'd1, 1'b0, 32100, 50, 32760, 50, 10, 10));
    offer(query_cmd(5'd1, 1'b0, 210, 32100, 210, 32767, 10, 10));
    offer(query_cmd(5'd2, 1'b1, 0, 0, 0, 0, 4095, 4095));
    offer(box_cmd(OP_UPDATE, 5'd0, -100, -100, 4095, 4095, 1'b0));
    offer(box_cmd(OP_UPDATE, 5'd31, 7, 7, 7, 7, 1'b0));
    offer(box_cmd(OP_UPDATE, 5'd2, -32768, -32768, 4095, 4095, 1'b1));
    offer(query_cmd(5'd3, 1'b1, 30, 30, 30, 30, 0, 0));
    offer(query_cmd(5'd4, 1'b0, 32767, 32767, -32768, -32768, 4095, 4095));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i % 120) >= 90;
      offer(random_cmd());
    end
    calm = 1'b0;
    cmd_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && results_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/acrt_pkg.sv
rtl/acrt_in_if.sv
rtl/acrt_out_if.sv
rtl/aabb_collision_resolve_table_unit.sv
rtl/acrt_checker.sv
tb/acrt_checker.sv
tb/tb.sv
